// File: design/rbs_pkg.sv
// Shared types, codes and constants for the ratio burst subflow scheduler.
`default_nettype none

package rbs_pkg;

  localparam int MAX_SUBFLOWS_DEF = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 8;
  localparam int DIV_W            = 16;
  localparam int MASK_W           = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BURST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SHARE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CWND_MODE   = 2'd2;

  localparam logic [7:0] TOTAL_BURST_RST = 8'd100;
  localparam logic [7:0] FIRST_SHARE_RST = 8'd77;

  localparam logic REQ_NEW      = 1'b0;
  localparam logic REQ_REINJECT = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANT  = 2'd0,
    ST_NONE   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK0,
    S_WALK1,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        subflow_count;
    logic [MASK_W-1:0] avail_loose_mask;
    logic [MASK_W-1:0] avail_cwnd_mask;
    logic [MASK_W-1:0] sent_mask;
    logic [15:0]       segment_len;
    logic [15:0]       seg_size;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  chosen_subflow;
    logic [23:0] limit_bytes;
    logic        clear_sent_mask;
  } result_t;

  function automatic logic mask_bit(input logic [MASK_W-1:0] m, input int unsigned idx);
    logic r;
    r = 1'b0;
    if (idx < MASK_W) r = m[idx[2:0]];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/rbs_quota_ram.sv
// Quota memory: one write and one registered read port, per-entry valid bits for reset.
`default_nettype none

module rbs_quota_ram #(
  parameter int DEPTH = rbs_pkg::MAX_SUBFLOWS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);
  import rbs_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] ent_valid;
  logic [7:0]       data_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (we) ent_valid[waddr] <= 1'b1;
      if (re) valid_q <= ent_valid[raddr];
    end
  end

  assign rdata = valid_q ? data_q : 8'd0;

endmodule

`default_nettype wire

// File: design/rbs_ceil_div.sv
// Serial restoring divider giving the rounded-up segment count.
`default_nettype none

module rbs_ceil_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rbs_pkg::DIV_W-1:0] dividend,
  input  logic [rbs_pkg::DIV_W-1:0] divisor,
  output logic                    done,
  output logic [rbs_pkg::DIV_W:0]   ceil_q
);
  import rbs_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= STEP_W'(step + 1'b1);
      if (step == STEP_W'(DIV_W - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= (divisor == '0) ? DIV_W'(1) : divisor;
    end else if (busy) begin
      rem <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign done   = !busy;
  assign ceil_q = {1'b0, quo} + {{DIV_W{1'b0}}, (rem != '0)};

endmodule

`default_nettype wire

// File: design/ratio_burst_subflow_scheduler.sv
// A new segment's result waits for the 16-step serial divider and for the quota walk (one
// memory entry a cycle, one or both passes), whichever ends later; a reinjection waits for neither.
// Throughput: one request at a time; the next is accepted the cycle after the result registers.
// Reset: synchronous; quotas read as zero at once through per-entry valid bits,
// registers return to 100, 77 and 0.
`default_nettype none

module ratio_burst_subflow_scheduler #(
  parameter int MAX_SUBFLOWS = rbs_pkg::MAX_SUBFLOWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rbs_pkg::req_t                 in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rbs_pkg::result_t              out_item
);
  import rbs_pkg::*;

  localparam int IDX_W = $clog2(MAX_SUBFLOWS);
  localparam int CNT_W = $clog2(MAX_SUBFLOWS + 1);

  logic [7:0] total_burst;
  logic [7:0] first_share;
  logic       cwnd_limit_mode;
  logic [7:0] share_even;

  state_t state, state_next;

  logic              req_r;
  logic [CNT_W-1:0]  n_r;
  logic [MASK_W-1:0] mask_r, cwm_r, sent_r;
  logic [15:0]       len_r, mss_r;

  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic             ev_valid, ev_valid_next;
  logic [IDX_W-1:0] ev_idx, ev_idx_next;
  logic             has_pick, has_pick_next;
  logic             any_seen, any_seen_next;
  logic [IDX_W-1:0] pick_idx, pick_idx_next;
  logic [7:0]       pick_q, pick_q_next;
  logic [7:0]       split, split_next;

  logic             ram_re, ram_we;
  logic [IDX_W-1:0] ram_raddr, ram_waddr;
  logic [7:0]       ram_wdata, q_rd;

  logic        div_start, div_done;
  logic [16:0] div_ceil;

  logic    out_load;
  result_t result_next;

  logic       ev_m, ev_found, ev_zero;
  logic [7:0] ev_share;
  logic [IDX_W-1:0] wk_idx;
  logic       wk_m;
  logic [7:0] wk_share;

  logic [MASK_W-1:0] in_range, ri_unsent, ri_sent;
  logic [2:0]        best_idx, backup_idx;
  logic [23:0]       prod;
  logic [7:0]        add_sat, new_q;
  logic [8:0]        sum9;

  rbs_quota_ram #(.DEPTH(MAX_SUBFLOWS)) u_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (ram_re),
    .raddr (ram_raddr),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rdata (q_rd)
  );

  rbs_ceil_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_item.segment_len),
    .divisor  (in_item.seg_size),
    .done     (div_done),
    .ceil_q   (div_ceil)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_burst     <= TOTAL_BURST_RST;
      first_share     <= FIRST_SHARE_RST;
      cwnd_limit_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_BURST: total_burst     <= cfg_data;
        CFG_FIRST_SHARE: first_share     <= cfg_data;
        CFG_CWND_MODE:   cwnd_limit_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign share_even = (first_share > total_burst) ? 8'd0 : 8'(total_burst - first_share);

  always_comb begin
    ev_m     = mask_bit(mask_r, 32'(ev_idx));
    ev_share = ev_idx[0] ? share_even : first_share;
    ev_found = ev_m && (ev_share != 8'd0) && (q_rd != 8'd0) && (q_rd < ev_share);
    ev_zero  = ev_m && (ev_share != 8'd0) && (q_rd == 8'd0);
    wk_idx   = rd_cnt[IDX_W-1:0];
    wk_m     = mask_bit(mask_r, 32'(wk_idx));
    wk_share = (n_r[0] ^ wk_idx[0]) ? share_even : first_share;
  end

  always_comb begin
    best_idx   = 3'd0;
    backup_idx = 3'd0;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      in_range[i] = 32'(n_r) > i;
    end
    ri_unsent = cwm_r & in_range & ~sent_r;
    ri_sent   = cwm_r & in_range & sent_r;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      if (ri_unsent[i]) best_idx = 3'(i);
      if (ri_sent[i]) backup_idx = 3'(i);
    end
  end

  always_comb begin
    prod    = {16'd0, split} * {8'd0, mss_r};
    add_sat = (len_r > mss_r) ? ((div_ceil > 17'd255) ? 8'hFF : div_ceil[7:0]) : 8'd1;
    sum9    = {1'b0, pick_q} + {1'b0, add_sat};
    new_q   = sum9[8] ? 8'hFF : sum9[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    rd_cnt_next   = rd_cnt;
    ev_valid_next = 1'b0;
    ev_idx_next   = ev_idx;
    has_pick_next = has_pick;
    any_seen_next = any_seen;
    pick_idx_next = pick_idx;
    pick_q_next   = pick_q;
    split_next    = split;
    ram_re        = 1'b0;
    ram_raddr     = rd_cnt[IDX_W-1:0];
    ram_we        = 1'b0;
    ram_waddr     = wk_idx;
    ram_wdata     = 8'd0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    result_next   = out_item;
    in_ready      = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          div_start     = 1'b1;
          rd_cnt_next   = '0;
          has_pick_next = 1'b0;
          any_seen_next = 1'b0;
          state_next    = (in_item.req_type == REQ_REINJECT) ? S_FINISH : S_WALK0;
        end
      end
      S_WALK0: begin
        if (ev_valid && ev_found) begin
          has_pick_next = 1'b1;
          pick_idx_next = ev_idx;
          pick_q_next   = q_rd;
          split_next    = 8'(ev_share - q_rd);
          state_next    = S_FINISH;
        end else begin
          if (ev_valid && ev_zero) begin
            has_pick_next = 1'b1;
            pick_idx_next = ev_idx;
            pick_q_next   = 8'd0;
            split_next    = ev_share;
          end
          if (ev_valid && ev_m) any_seen_next = 1'b1;
          if (rd_cnt != n_r) begin
            ram_re        = 1'b1;
            rd_cnt_next   = CNT_W'(rd_cnt + 1'b1);
            ev_valid_next = 1'b1;
            ev_idx_next   = rd_cnt[IDX_W-1:0];
          end else if (!ev_valid) begin
            if (!has_pick && any_seen) begin
              rd_cnt_next = '0;
              state_next  = S_WALK1;
            end else begin
              state_next  = S_FINISH;
            end
          end
        end
      end
      S_WALK1: begin
        if (wk_m) begin
          ram_we = 1'b1;
          if (wk_share != 8'd0) begin
            has_pick_next = 1'b1;
            pick_idx_next = wk_idx;
            pick_q_next   = 8'd0;
            split_next    = wk_share;
          end
        end
        rd_cnt_next = CNT_W'(rd_cnt + 1'b1);
        if (CNT_W'(rd_cnt + 1'b1) == n_r) state_next = S_FINISH;
      end
      S_FINISH: begin
        if ((req_r || div_done) && (!out_valid || out_ready)) begin
          out_load    = 1'b1;
          state_next  = S_IDLE;
          result_next = '{status: ST_NONE, chosen_subflow: 3'd0, limit_bytes: 24'd0,
                          clear_sent_mask: 1'b0};
          if (req_r) begin
            if (ri_unsent != '0) begin
              result_next.status         = ST_GRANT;
              result_next.chosen_subflow = best_idx;
            end else if (ri_sent != '0) begin
              result_next.status          = ST_GRANT;
              result_next.chosen_subflow  = backup_idx;
              result_next.clear_sent_mask = 1'b1;
            end
          end else if (has_pick) begin
            if (!mask_bit(cwm_r, 32'(pick_idx))) begin
              result_next.status = ST_REJECT;
            end else begin
              ram_we                     = 1'b1;
              ram_waddr                  = pick_idx;
              ram_wdata                  = new_q;
              result_next.status         = ST_GRANT;
              result_next.chosen_subflow = 3'(pick_idx);
              result_next.limit_bytes    = prod;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= ev_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt   <= rd_cnt_next;
    ev_idx   <= ev_idx_next;
    has_pick <= has_pick_next;
    any_seen <= any_seen_next;
    pick_idx <= pick_idx_next;
    pick_q   <= pick_q_next;
    split    <= split_next;
    if (state == S_IDLE && in_valid) begin
      req_r  <= in_item.req_type;
      n_r    <= (32'(in_item.subflow_count) > MAX_SUBFLOWS) ? CNT_W'(MAX_SUBFLOWS)
                                                            : CNT_W'(in_item.subflow_count);
      mask_r <= cwnd_limit_mode ? in_item.avail_cwnd_mask : in_item.avail_loose_mask;
      cwm_r  <= in_item.avail_cwnd_mask;
      sent_r <= in_item.sent_mask;
      len_r  <= in_item.segment_len;
      mss_r  <= in_item.seg_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= result_next;
  end

endmodule

`default_nettype wire

// File: design/rbs_checker.sv
// Port-level assertions for the scheduler and their bind to the top level.
`default_nettype none

module rbs_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rbs_pkg::result_t out_item
);
  import rbs_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while a request is in flight");

  a_no_grant_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != ST_GRANT) |->
      (out_item.limit_bytes == 24'd0) && (out_item.chosen_subflow == 3'd0) &&
      !out_item.clear_sent_mask)
    else $error("result without grant carries a choice");

  a_clear_only_on_reinject_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.clear_sent_mask |->
      (out_item.status == ST_GRANT) && (out_item.limit_bytes == 24'd0))
    else $error("sent mask clear outside a reinjection grant");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

endmodule

bind ratio_burst_subflow_scheduler rbs_checker u_rbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
